>>> rtl/core/aesm_pkg.sv
// aesm_pkg: shared constants, s-box tables and round functions for the aes mode engine
// no dependencies
package aesm_pkg;

  localparam int MAX_ROUNDS_DEF = 14;

  localparam logic [1:0] MODE_DIRECT      = 2'd0;
  localparam logic [1:0] MODE_XORCHAIN    = 2'd1;
  localparam logic [1:0] MODE_CIPHER_FEED = 2'd2;
  localparam logic [1:0] MODE_OUTPUT_FEED = 2'd3;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_IV_HIGH = 3'd4;
  localparam logic [2:0] REG_IV_LOW  = 3'd5;
  localparam logic [2:0] REG_CONTROL = 3'd6;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] ISBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX_TBL[{~b, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] b);
    return ISBOX_TBL[{~b, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a state counts from the top end, byte 0 most significant
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (i + 4 * c) -: 8] = sbox(byte_of(s, i + 4 * ((c + i) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(t, 4 * c);
      a1 = byte_of(t, 4 * c + 1);
      a2 = byte_of(t, 4 * c + 2);
      a3 = byte_of(t, 4 * c + 3);
      m[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    return (last ? t : m) ^ k;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x2, x4, x8;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    return (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
         ^ (b[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8] = isbox(byte_of(s, i + 4 * c));
      end
    end
    t = t ^ k;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(t, 4 * c);
      a1 = byte_of(t, 4 * c + 1);
      a2 = byte_of(t, 4 * c + 2);
      a3 = byte_of(t, 4 * c + 3);
      m[127 - 32 * c -: 32] = {gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9),
                               gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13),
                               gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11),
                               gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14)};
    end
    return last ? t : m;
  endfunction

endpackage

>>> rtl/core/aes_block_mode_engine_unit.sv
// aes_block_mode_engine_unit: aes-128/192/256 with ecb, cbc, cfb and ofb chaining
// depends on aesm_pkg for the s-boxes and the round functions
//
// One word of 128 bits (or one cfb segment in its leading bytes) goes in, one word comes out.
// A single round unit does one aes round per cycle; a word goes through the key addition at
// accept, Nr rounds (Nr is capped at MAX_ROUNDS) and a done state, and no new word is taken
// before it is through. After reset and after every write to a key register or the control
// register the key schedule is rebuilt one 32-bit word per cycle, 4 * (Nr + 1) words (44, 52
// or 60), and no word is taken meanwhile, nor in the cycle of such a write. A finished result
// sits in an output register, so the next word can be taken while it waits. Writing iv_high
// or iv_low reloads that half of the chaining value.
module aes_block_mode_engine_unit
  import aesm_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic        op,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int RK_ROWS = MAX_ROUNDS + 1;
  localparam int RKW     = $clog2(RK_ROWS);
  localparam int RW      = $clog2(MAX_ROUNDS + 1);
  localparam int WW      = $clog2(4 * RK_ROWS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]   st;
  logic [63:0]  key_word [4];
  logic [7:0]   ctl;
  logic [127:0] chain;
  logic [127:0] rk [RK_ROWS];
  logic [31:0]  hist [8];
  logic [WW-1:0] wi;
  logic [2:0]   kmod;
  logic [7:0]   rcon;
  logic [127:0] aes;
  logic [127:0] data_reg;
  logic         op_reg;
  logic         inv_op;
  logic [RW-1:0] rnd;

  logic [3:0]   nk;
  logic [RW-1:0] nr;
  logic [WW-1:0] total;
  logic [31:0]  t_word, new_word;
  logic [RKW-1:0] rk_addr;
  logic [127:0] rk_row;
  logic         data_acc;
  logic         inv_in;
  logic [127:0] data_in;
  logic [127:0] aes_in;
  logic         last_round;
  logic [4:0]   seg;
  logic [127:0] seg_mask;
  logic [127:0] res_val, chain_next, cfb_res, fb;
  logic         out_free;
  logic         restart;
  logic         word_done;

  // key or control writes rebuild the schedule
  assign restart    = cfg_valid && cfg_ready &&
                      (cfg_index <= REG_KEY3 || cfg_index == REG_CONTROL);
  assign cfg_ready  = 1'b1;
  assign data_stall = (st != ST_IDLE) || restart;
  assign data_acc   = data_valid && !data_stall;
  assign out_free   = !result_valid || !result_stall;
  assign word_done  = (st == ST_DONE) && out_free && !restart;

  // key schedule sizing
  always_comb begin
    case (ctl[3:2])
      KEY_128: nk = 4'd4;
      KEY_192: nk = 4'd6;
      default: nk = 4'd8;
    endcase
    if (32'(nk) + 6 > MAX_ROUNDS) nr = RW'(MAX_ROUNDS);
    else nr = RW'(nk) + RW'(6);
    total = WW'(4) * (WW'(nr) + WW'(1));
  end

  // one schedule word per cycle
  always_comb begin
    t_word = hist[0];
    if (kmod == 3'd0) begin
      t_word = sub_word({hist[0][23:0], hist[0][31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      t_word = sub_word(hist[0]);
    end
    if (wi < WW'(nk)) begin
      new_word = wi[0] ? key_word[wi[2:1]][31:0] : key_word[wi[2:1]][63:32];
    end else begin
      new_word = hist[3'(nk - 4'd1)] ^ t_word;
    end
  end

  assign data_in = {block_high, block_low};
  assign inv_in  = op && (ctl[1:0] == MODE_DIRECT || ctl[1:0] == MODE_XORCHAIN);

  always_comb begin
    case (ctl[1:0])
      MODE_DIRECT:   aes_in = data_in;
      MODE_XORCHAIN: aes_in = op ? data_in : (data_in ^ chain);
      default:       aes_in = chain;
    endcase
  end

  assign rk_addr    = (st == ST_IDLE) ? (inv_in ? RKW'(nr) : '0) : RKW'(rnd);
  assign rk_row     = rk[rk_addr];
  assign last_round = inv_op ? (rnd == '0) : (rnd == nr);

  // result and chaining update once the cipher is done
  always_comb begin
    seg      = {1'b0, ctl[7:4]} + 5'd1;
    seg_mask = ~128'h0 << {4'd15 - ctl[7:4], 3'b000};
    cfb_res  = (data_reg ^ aes) & seg_mask;
    fb       = op_reg ? (data_reg & seg_mask) : cfb_res;
    case (ctl[1:0])
      MODE_DIRECT: begin
        res_val    = aes;
        chain_next = chain;
      end
      MODE_XORCHAIN: begin
        res_val    = op_reg ? (aes ^ chain) : aes;
        chain_next = op_reg ? data_reg : aes;
      end
      MODE_CIPHER_FEED: begin
        res_val    = cfb_res;
        chain_next = (chain << {seg, 3'b000}) | (fb >> {4'd15 - ctl[7:4], 3'b000});
      end
      default: begin
        res_val    = data_reg ^ aes;
        chain_next = aes;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_EXPAND;
      wi           <= '0;
      kmod         <= '0;
      rcon         <= 8'h01;
      ctl          <= '0;
      chain        <= '0;
      result_valid <= 1'b0;
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
    end else begin
      if (word_done) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;

      if (cfg_valid && cfg_ready && cfg_index == REG_IV_HIGH) chain[127:64] <= cfg_data;
      else if (cfg_valid && cfg_ready && cfg_index == REG_IV_LOW) chain[63:0] <= cfg_data;
      else if (word_done) chain <= chain_next;

      if (restart) begin
        st   <= ST_EXPAND;
        wi   <= '0;
        kmod <= '0;
        rcon <= 8'h01;
      end else begin
        case (st)
          ST_EXPAND: begin
            rk[wi[RKW+1:2]][(3 - 32'(wi[1:0])) * 32 +: 32] <= new_word;
            hist[0] <= new_word;
            for (int k = 1; k < 8; k++) hist[k] <= hist[k-1];
            if (wi >= WW'(nk) && kmod == 3'd0) rcon <= xt(rcon);
            kmod <= (kmod == 3'(nk - 4'd1)) ? 3'd0 : kmod + 3'd1;
            wi   <= wi + WW'(1);
            if (wi == total - WW'(1)) st <= ST_IDLE;
          end
          ST_IDLE: begin
            if (data_acc) begin
              aes      <= aes_in ^ rk_row;
              data_reg <= data_in;
              op_reg   <= op;
              inv_op   <= inv_in;
              rnd      <= inv_in ? nr - RW'(1) : RW'(1);
              st       <= ST_RUN;
            end
          end
          ST_RUN: begin
            aes <= inv_op ? inv_round(aes, rk_row, last_round)
                          : fwd_round(aes, rk_row, last_round);
            rnd <= inv_op ? rnd - RW'(1) : rnd + RW'(1);
            if (last_round) st <= ST_DONE;
          end
          ST_DONE: begin
            if (out_free) begin
              result_high <= res_val[127:64];
              result_low  <= res_val[63:0];
              st          <= ST_IDLE;
            end
          end
          default: st <= ST_IDLE;
        endcase
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[cfg_index[1:0]] <= cfg_data;
          REG_CONTROL: ctl <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    data_acc && !cfg_valid |=> st == ST_RUN)
    else $error("accepted word did not start the round unit");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_RUN |-> rnd <= nr)
    else $error("round counter beyond round count");

  a_expand_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_EXPAND |-> wi < total)
    else $error("key schedule index beyond schedule length");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    st == ST_DONE && out_free && !cfg_valid |=> result_valid && st == ST_IDLE)
    else $error("finished word not moved to output register");

endmodule

>>> verif/testbench.sv
// testbench for aes_block_mode_engine_unit: directed table then random words in all modes
// depends on aesm_pkg and the engine rtl; predicts every result with its own aes model
`timescale 1ns / 1ps
module testbench;
  import aesm_pkg::*;

  typedef struct {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        has_exp;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic        op = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_block_mode_engine_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0]  key_words[4];
  logic [7:0]   ctrl_reg;
  logic [127:0] chain_reg;
  logic [31:0]  sched[60];
  int           nrounds;

  logic [127:0] exp_q[$];
  int           n_err = 0;
  int           n_words = 0;
  int           n_results = 0;
  int           n_cfg = 0;
  longint       cycles = 0;
  bit           drain_mode = 0;
  int           mode_hits[4];

  function automatic logic [7:0] gf_x2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_x2(a);
    end
    return p;
  endfunction

  logic [7:0] fsub[256];
  logic [7:0] isub[256];

  // s-box built from field inverse and affine map
  task automatic build_sbox();
    logic [7:0] inv, b;
    for (int i = 0; i < 256; i++) begin
      inv = 1;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, i[7:0]);
      if (i == 0) inv = 0;
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fsub[i] = b;
      isub[b] = i[7:0];
    end
  endtask

  function automatic logic [31:0] sw4(logic [31:0] w);
    return {fsub[w[31:24]], fsub[w[23:16]], fsub[w[15:8]], fsub[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int nk, tot;
    logic [7:0] rc;
    logic [31:0] t;
    nk = (ctrl_reg[3:2] == KEY_128) ? 4 : (ctrl_reg[3:2] == KEY_192) ? 6 : 8;
    nrounds = nk + 6;
    if (nrounds > MAX_ROUNDS_DEF) nrounds = MAX_ROUNDS_DEF;
    tot = 4 * (nrounds + 1);
    rc = 1;
    for (int i = 0; i < 60; i++) sched[i] = 0;
    for (int i = 0; i < tot; i++) begin
      if (i < nk) begin
        sched[i] = (i % 2) ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
      end else begin
        t = sched[i - 1];
        if (i % nk == 0) begin
          t = sw4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_x2(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sw4(t);
        end
        sched[i] = sched[i - nk] ^ t;
      end
    end
  endtask

  function automatic logic [7:0] bget(logic [127:0] s, int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function automatic logic [127:0] rkey(int r);
    return {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  endfunction

  function automatic logic [127:0] cipher_fwd(logic [127:0] in);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3;
    s = in ^ rkey(0);
    for (int r = 1; r <= nrounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[127 - 8 * (i + 4 * c) -: 8] = fsub[bget(s, i + 4 * ((c + i) % 4))];
      if (r != nrounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = bget(t, 4 * c); a1 = bget(t, 4 * c + 1);
          a2 = bget(t, 4 * c + 2); a3 = bget(t, 4 * c + 3);
          s[127 - 32 * c -: 32] = {gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3,
                                   a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3,
                                   a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3,
                                   gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3)};
        end
      end else s = t;
      s ^= rkey(r);
    end
    return s;
  endfunction

  function automatic logic [127:0] cipher_inv(logic [127:0] in);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3;
    s = in ^ rkey(nrounds);
    for (int r = nrounds - 1; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8] = isub[bget(s, i + 4 * c)];
      t ^= rkey(r);
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = bget(t, 4 * c); a1 = bget(t, 4 * c + 1);
          a2 = bget(t, 4 * c + 2); a3 = bget(t, 4 * c + 3);
          s[127 - 32 * c -: 32] = {
            gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9),
            gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13),
            gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11),
            gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14)};
        end
      end else s = t;
    end
    return s;
  endfunction

  function automatic logic [127:0] predict_block(logic dec, logic [127:0] d);
    logic [127:0] res, ks, fb;
    int seg;
    res = '0;
    seg = ctrl_reg[7:4] + 1;
    case (ctrl_reg[1:0])
      MODE_DIRECT: res = dec ? cipher_inv(d) : cipher_fwd(d);
      MODE_XORCHAIN: begin
        if (dec) begin
          res = cipher_inv(d) ^ chain_reg;
          chain_reg = d;
        end else begin
          res = cipher_fwd(d ^ chain_reg);
          chain_reg = res;
        end
      end
      MODE_CIPHER_FEED: begin
        ks = cipher_fwd(chain_reg);
        for (int j = 0; j < seg; j++)
          res[127 - 8 * j -: 8] = bget(d, j) ^ bget(ks, j);
        fb = dec ? d : res;
        // shift out seg bytes, feed the segment in at the tail
        chain_reg = (chain_reg << (8 * seg)) | (fb >> (8 * (16 - seg)));
      end
      default: begin
        ks = cipher_fwd(chain_reg);
        chain_reg = ks;
        res = d ^ ks;
      end
    endcase
    mode_hits[ctrl_reg[1:0]]++;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx <= REG_KEY3) begin
      key_words[idx[1:0]] = val;
      expand_schedule();
    end else if (idx == REG_IV_HIGH) chain_reg[127:64] = val;
    else if (idx == REG_IV_LOW) chain_reg[63:0] = val;
    else if (idx == REG_CONTROL) begin
      ctrl_reg = val[7:0];
      expand_schedule();
    end
  endtask

  // drop valid, wait for all words out, then let the engine settle
  task automatic wait_idle();
    data_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (drain_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays up after an accept when the next word follows without a gap
  task automatic send_word(logic o, logic [63:0] h, logic [63:0] l,
                           bit has_exp, logic [127:0] ex);
    logic [127:0] pr;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    op <= o;
    block_high <= h;
    block_low <= l;
    do @(posedge clk); while (data_stall);
    pr = predict_block(o, {h, l});
    if (has_exp && pr !== ex) begin
      n_err++;
      if (n_err <= 10) $display("table entry mismatch: exp %h got %h", ex, pr);
    end
    exp_q.push_back(pr);
    n_words++;
    @(negedge clk);
  endtask

  // receiver side: random stalls, compare each accepted word
  initial begin
    forever begin
      @(negedge clk);
      if (!rst) begin
        if (drain_mode) result_stall <= 1'b0;
        else result_stall <= ($urandom_range(0, 99) < 25) ||
                             ($urandom_range(0, 199) == 0);
      end
    end
  end

  always @(posedge clk) begin
    logic [127:0] e;
    cycles++;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word %h_%h", result_high, result_low);
      end else begin
        e = exp_q.pop_front();
        if (result_high !== e[127:64] || result_low !== e[63:0]) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp %h_%h got %h_%h", e[127:64], e[63:0],
                     result_high, result_low);
        end
      end
    end
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed vectors (zero key and fips-197) read off at a glance
  stim_row_t dir_tbl[$];

  task automatic random_cfg();
    logic [7:0] c;
    for (int k = 0; k < 4; k++)
      write_reg(k[2:0], {$urandom, $urandom});
    c = 8'($urandom_range(0, 255));
    write_reg(REG_CONTROL, 64'(c));
    write_reg(REG_IV_HIGH, {$urandom, $urandom});
    write_reg(REG_IV_LOW, {$urandom, $urandom});
  endtask

  initial begin
    stim_row_t row;
    logic [63:0] h, l;
    int n;
    build_sbox();
    for (int k = 0; k < 4; k++) key_words[k] = 0;
    ctrl_reg = 0;
    chain_reg = 0;
    expand_schedule();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset state: zero key ecb, first two words checked against known values
    dir_tbl = '{
      '{1'b0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
      '{1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
      '{1'b1, '1, '1, 1'b0, 64'h0, 64'h0}};
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_word(row.op, row.hi, row.lo, row.has_exp, {row.exp_hi, row.exp_lo});
    end
    wait_idle();
    // fips-197 aes-128 key
    write_reg(REG_KEY0, 64'h0001020304050607);
    write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_reg(REG_KEY2, 64'h1011121314151617);
    write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
    dir_tbl = '{
      '{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}};
    send_word(dir_tbl[0].op, dir_tbl[0].hi, dir_tbl[0].lo, 1'b1,
              {dir_tbl[0].exp_hi, dir_tbl[0].exp_lo});
    wait_idle();
    // every mode and key size, including key code three and segment extremes
    for (int m = 0; m < 4; m++) begin
      for (int ks = 0; ks < 4; ks++) begin
        write_reg(REG_CONTROL, 64'({(ks[0] ? 4'hf : 4'h0), ks[1:0], m[1:0]}));
        write_reg(REG_IV_HIGH, {$urandom, $urandom});
        write_reg(REG_IV_LOW, '1);
        send_word(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 0, '0);
        send_word(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 0, '0);
        wait_idle();
      end
    end

    // random phases; each phase keeps a chain of words under one setting
    n = 0;
    while (n < 1750) begin
      random_cfg();
      drain_mode = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(5, 40)) begin
        h = {$urandom, $urandom};
        l = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? '0 : '1;
        send_word(1'($urandom_range(0, 1)), h, l, 0, '0);
        n++;
      end
      wait_idle();
      drain_mode = 0;
    end
    wait_idle();
    $display("%0d words and %0d register writes; ecb %0d cbc %0d cfb %0d ofb %0d",
             n_words, n_cfg, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d errors, %0d words outstanding", n_err, exp_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/aesm_pkg.sv
rtl/core/aes_block_mode_engine_unit.sv
verif/testbench.sv
